// File: design/gmse_pkg.sv
// Package for the graphics-mode scanline expander.
// Shared types, register indexes, mode codes and the row-count table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gmse_pkg;

   localparam int CSR_INDEX_W  = 8;
   localparam int CSR_DATA_W   = 8;
   localparam int MAX_RESULTS  = 48;
   localparam int EMIT_CNT_W   = $clog2(MAX_RESULTS);
   localparam int BYTE_PIX_MAX = 16;
   localparam int BYTE_PIX_W   = 5;
   localparam int OUT_W        = 64;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_GRAPHICS_MODE = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLOR_SET     = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FG_SET0       = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FG_SET1       = 8'd3;

   // graphics mode codes
   localparam logic [2:0] MODE_1C = 3'd0;
   localparam logic [2:0] MODE_1R = 3'd1;
   localparam logic [2:0] MODE_2C = 3'd2;
   localparam logic [2:0] MODE_2R = 3'd3;
   localparam logic [2:0] MODE_3C = 3'd4;
   localparam logic [2:0] MODE_3R = 3'd5;
   localparam logic [2:0] MODE_6C = 3'd6;
   localparam logic [2:0] MODE_6R = 3'd7;

   localparam logic [3:0] FG_SET0_RESET = 4'd1;
   localparam logic [3:0] FG_SET1_RESET = 4'd5;

   typedef struct packed {
      logic [2:0] graphics_mode;
      logic       color_set_select;
      logic [3:0] fg_index_set0;
      logic [3:0] fg_index_set1;
   } cfg_type;

   typedef struct packed {
      logic load_byte;   // capture a new video byte
      logic chunk;       // place one run of pixels into the line
      logic emit_issue;  // read the next group toward the output
   } dp_cmd_type;

   typedef struct packed {
      logic byte_done;   // this chunk finishes the byte
      logic line_done;   // this chunk fills the line
      logic emit_last;   // the group being issued ends the run
   } dp_status_type;

   function automatic logic [1:0] rows_for_mode(input logic [2:0] mode);
      logic [1:0] rows;
      unique case (mode)
         MODE_1C, MODE_1R, MODE_2C: rows = 2'd3;
         MODE_2R, MODE_3C:          rows = 2'd2;
         default:                   rows = 2'd1;
      endcase
      return rows;
   endfunction

endpackage

`default_nettype wire

// File: design/graphics_mode_scanline_expander_core.sv
// Top level of the graphics-mode scanline expander: configuration registers,
// controller and datapath. Depends on gmse_pkg, gmse_ctrl and gmse_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Each video byte is expanded to 8 or 16 palette indices and packed into a
// line of LINE_PIXELS pixels. After the accept, a byte is placed as runs of
// pixels up to the next group boundary (one or two runs at the default
// sizes); the next byte is taken while the last run of the current one is
// placed, unless that run fills the line. When the line is full it is
// replayed from the line RAM, one group per cycle while the output is not
// stalled, over its single read port, rows x groups groups in all (at most
// 48). Mode 1C at defaults: 16 bytes and 48 groups per line. The RAM read
// register is the output register, so the next line may start filling while
// the final group waits. The line RAM needs no clearing pass.
module graphics_mode_scanline_expander_core
   import gmse_pkg::*;
#(
   parameter int LINE_PIXELS  = 256,
   parameter int GROUP_PIXELS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire logic [7:0]             req_video_byte,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      logic [OUT_W-1:0]       rsp_pixel_group,
   output      logic                   rsp_last_of_run,
   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type       cfg_ff, cfg_in;
   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_GRAPHICS_MODE: cfg_in.graphics_mode    = csr_wdata[2:0];
            CSR_COLOR_SET:     cfg_in.color_set_select = csr_wdata[0];
            CSR_FG_SET0:       cfg_in.fg_index_set0    = csr_wdata[3:0];
            CSR_FG_SET1:       cfg_in.fg_index_set1    = csr_wdata[3:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.graphics_mode    <= MODE_1C;
         cfg_ff.color_set_select <= 1'b0;
         cfg_ff.fg_index_set0    <= FG_SET0_RESET;
         cfg_ff.fg_index_set1    <= FG_SET1_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gmse_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .cmd      (cmd),
      .status   (status)
   );

   gmse_datapath #(
      .LINE_PIXELS (LINE_PIXELS),
      .GROUP_PIXELS(GROUP_PIXELS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .cmd        (cmd),
      .status     (status),
      .video_byte (req_video_byte),
      .pixel_group(rsp_pixel_group),
      .last_of_run(rsp_last_of_run)
   );

endmodule

`default_nettype wire

// File: design/gmse_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module gmse_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: design/gmse_datapath.sv
// Datapath: byte expansion, group assembly, line store and line replay.
// Depends on gmse_pkg and gmse_ram.
`timescale 1ns / 1ps
`default_nettype none

module gmse_datapath
   import gmse_pkg::*;
#(
   parameter int LINE_PIXELS  = 256,
   parameter int GROUP_PIXELS = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cfg_type       cfg,
   input  wire dp_cmd_type    cmd,
   output      dp_status_type status,
   input  wire logic [7:0]    video_byte,
   output      logic [OUT_W-1:0] pixel_group,
   output      logic          last_of_run
);

   localparam int GPL    = (LINE_PIXELS + GROUP_PIXELS - 1) / GROUP_PIXELS;
   localparam int AW     = $clog2(GPL);
   localparam int FILL_W = $clog2(LINE_PIXELS + 1);
   localparam int SLOT_W = $clog2(GROUP_PIXELS + 1);
   localparam int GW     = 4 * GROUP_PIXELS;

   localparam logic [3:0] MONO_GREEN = 4'd1;
   localparam logic [3:0] MONO_BUFF  = 4'd5;

   logic [7:0]            byte_ff, byte_in;
   logic [BYTE_PIX_W-1:0] off_ff, off_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [AW-1:0]         grp_ff, grp_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic [GW-1:0]         acc_ff, acc_in;
   logic [AW-1:0]         egrp_ff, egrp_in;
   logic [1:0]            erow_ff, erow_in;
   logic [1:0]            rows_ff, rows_in;
   logic [EMIT_CNT_W-1:0] ecnt_ff, ecnt_in;
   logic                  last_ff, last_in;

   logic [3:0]            pix [BYTE_PIX_MAX];
   logic [BYTE_PIX_W-1:0] npix, rem_b, rem_g, c0, cnt;
   logic [FILL_W-1:0]     rem_l;
   logic                  grp_full, line_done, byte_done, flush, emit_last;
   logic [GW-1:0]         acc_next;
   logic [3:0]            fg_sel, mono;
   logic [GW-1:0]         rdata;

   // ---- expansion of the held byte into up to sixteen palette indices ----
   assign fg_sel = cfg.color_set_select ? cfg.fg_index_set1 : cfg.fg_index_set0;
   assign mono   = (fg_sel == MONO_GREEN) ? MONO_GREEN : MONO_BUFF;
   assign npix   = (cfg.graphics_mode == MODE_1C ||
                    (cfg.graphics_mode[0] && cfg.graphics_mode != MODE_6R))
                   ? BYTE_PIX_W'(16) : BYTE_PIX_W'(8);

   always_comb begin
      logic [3:0] iv;
      logic [1:0] k;
      logic [2:0] bi;
      logic [1:0] fld;
      for (int i = 0; i < BYTE_PIX_MAX; i++) begin
         iv  = 4'(i);
         k   = (cfg.graphics_mode == MODE_1C) ? iv[3:2] : iv[2:1];
         fld = 2'(byte_ff >> {~k, 1'b0});
         bi  = (cfg.graphics_mode == MODE_6R) ? iv[2:0] : iv[3:1];
         if (!cfg.graphics_mode[0]) begin
            pix[i] = 4'({1'b0, cfg.color_set_select, fld}) + 4'd1;
         end else if (cfg.graphics_mode == MODE_6R) begin
            pix[i] = byte_ff[~bi] ? mono : 4'd0;
         end else begin
            pix[i] = byte_ff[~bi] ? fg_sel : 4'd0;
         end
      end
   end

   // ---- run length: bounded by byte, group and line ----
   always_comb begin
      rem_b = npix - off_ff;
      rem_g = BYTE_PIX_W'(SLOT_W'(GROUP_PIXELS) - slot_ff);
      c0    = (rem_b < rem_g) ? rem_b : rem_g;
      rem_l = FILL_W'(LINE_PIXELS) - fill_ff;
      cnt   = (FILL_W'(c0) > rem_l) ? BYTE_PIX_W'(rem_l) : c0;
   end

   assign line_done = (fill_ff + FILL_W'(cnt)) == FILL_W'(LINE_PIXELS);
   assign grp_full  = (6'(slot_ff) + 6'(cnt)) == 6'(GROUP_PIXELS);
   assign byte_done = ((off_ff + cnt) == npix) || line_done;
   assign flush     = grp_full || line_done;

   always_comb begin
      logic [5:0] pos;
      acc_next = acc_ff;
      for (int j = 0; j < GROUP_PIXELS; j++) begin
         pos = 6'(j) - 6'(slot_ff) + 6'(off_ff);
         if (6'(j) >= 6'(slot_ff) && 6'(j) < 6'(slot_ff) + 6'(cnt)) begin
            acc_next[GW-4-4*j +: 4] = pix[pos[3:0]];
         end
      end
   end

   // ---- replay counters ----
   assign emit_last = (egrp_ff == AW'(GPL - 1) && erow_ff == rows_ff - 2'd1) ||
                      (ecnt_ff == EMIT_CNT_W'(MAX_RESULTS - 1));

   always_comb begin
      byte_in = cmd.load_byte ? video_byte : byte_ff;
      off_in  = off_ff;
      slot_in = slot_ff;
      grp_in  = grp_ff;
      fill_in = fill_ff;
      acc_in  = acc_ff;
      egrp_in = egrp_ff;
      erow_in = erow_ff;
      rows_in = rows_ff;
      ecnt_in = ecnt_ff;
      last_in = last_ff;
      if (cmd.chunk) begin
         off_in  = byte_done ? '0 : off_ff + cnt;
         fill_in = line_done ? '0 : fill_ff + FILL_W'(cnt);
         if (flush) begin
            acc_in  = '0;
            slot_in = '0;
            grp_in  = line_done ? '0 : grp_ff + AW'(1);
         end else begin
            acc_in  = acc_next;
            slot_in = slot_ff + SLOT_W'(cnt);
         end
         if (line_done) begin
            egrp_in = '0;
            erow_in = '0;
            ecnt_in = '0;
            rows_in = rows_for_mode(cfg.graphics_mode);
         end
      end
      if (cmd.load_byte) begin
         off_in = '0;
      end
      if (cmd.emit_issue) begin
         last_in = emit_last;
         ecnt_in = ecnt_ff + EMIT_CNT_W'(1);
         if (egrp_ff == AW'(GPL - 1)) begin
            egrp_in = '0;
            erow_in = erow_ff + 2'd1;
         end else begin
            egrp_in = egrp_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff  <= '0;
         slot_ff <= '0;
         grp_ff  <= '0;
         fill_ff <= '0;
         acc_ff  <= '0;
         egrp_ff <= '0;
         erow_ff <= '0;
         rows_ff <= 2'd1;
         ecnt_ff <= '0;
      end else begin
         off_ff  <= off_in;
         slot_ff <= slot_in;
         grp_ff  <= grp_in;
         fill_ff <= fill_in;
         acc_ff  <= acc_in;
         egrp_ff <= egrp_in;
         erow_ff <= erow_in;
         rows_ff <= rows_in;
         ecnt_ff <= ecnt_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   // line store; its read register is the output register
   gmse_ram #(
      .WIDTH(GW),
      .DEPTH(GPL)
   ) u_line_ram (
      .clock(clock),
      .we   (cmd.chunk && flush),
      .waddr(grp_ff),
      .wdata(acc_next),
      .re   (cmd.emit_issue),
      .raddr(egrp_ff),
      .rdata(rdata)
   );

   assign pixel_group      = OUT_W'(rdata);
   assign last_of_run      = last_ff;
   assign status.byte_done = byte_done;
   assign status.line_done = line_done;
   assign status.emit_last = emit_last;

endmodule

`default_nettype wire

// File: design/gmse_ctrl.sv
// Controller: accepts bytes, sequences pixel runs and replays the line.
// Depends on gmse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gmse_ctrl
   import gmse_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output      logic          req_stall,
   output      logic          rsp_valid,
   input  wire logic          rsp_stall,
   output      dp_cmd_type    cmd,
   input  wire dp_status_type status
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_EXPAND = 2'd1;
   localparam logic [1:0] S_EMIT   = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept, issue;

   always_comb begin
      req_stall = 1'b1;
      issue     = 1'b0;
      unique case (state_ff)
         S_IDLE:   req_stall = 1'b0;
         // next byte may enter on the last run of the current one
         S_EXPAND: req_stall = !(status.byte_done && !status.line_done);
         S_EMIT:   issue     = !rsp_valid_ff || !rsp_stall;
         default:  req_stall = 1'b1;
      endcase
   end

   assign accept = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_EXPAND;
         end
         S_EXPAND: begin
            if (status.line_done)      state_in = S_EMIT;
            else if (status.byte_done) state_in = accept ? S_EXPAND : S_IDLE;
         end
         S_EMIT: begin
            if (issue && status.emit_last) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (issue)           rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
      else                 rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign cmd.load_byte  = accept;
   assign cmd.chunk      = (state_ff == S_EXPAND);
   assign cmd.emit_issue = issue;
   assign rsp_valid      = rsp_valid_ff;

endmodule

`default_nettype wire

// File: design/gmse_checker.sv
// Port-level checks for the scanline expander, bound to the top level.
// Depends on gmse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gmse_checker
   import gmse_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_stall,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire logic [OUT_W-1:0] rsp_pixel_group,
   input wire logic             rsp_last_of_run
);

   // nothing is offered right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_group) &&
                                 $stable(rsp_last_of_run))
      else $error("stalled result changed");

   // replay runs without gaps until the final group
   a_run_gapless: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_of_run |=> rsp_valid)
      else $error("gap inside a replayed line");

   // no byte enters while a line is being replayed
   a_no_input_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> req_stall)
      else $error("input taken during line replay");

endmodule

bind graphics_mode_scanline_expander_core gmse_checker u_gmse_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_pixel_group(rsp_pixel_group),
   .rsp_last_of_run(rsp_last_of_run)
);

`default_nettype wire

// File: tb/sv/tb_graphics_mode_scanline_expander_core.sv
// Self-checking testbench for graphics_mode_scanline_expander_core.
// Predicts each scanline's pixel groups from the video bytes and the register
// settings, and compares every output transfer. Depends on gmse_pkg.
`timescale 1ns / 1ps

module tb_graphics_mode_scanline_expander_core
   import gmse_pkg::*;
();

   localparam int LINE_PIXELS     = 256;
   localparam int GROUP_PIXELS    = 16;
   localparam int GROUPS_PER_LINE = (LINE_PIXELS + GROUP_PIXELS - 1) / GROUP_PIXELS;
   localparam int SETTLE_CYCLES   = 16;
   localparam int HOLD_CYCLES     = 400;
   localparam int MAX_REPORTS     = 10;

   localparam logic [3:0] PIX_BLACK = 4'd0;
   localparam logic [3:0] PIX_GREEN = 4'd1;
   localparam logic [3:0] PIX_BUFF  = 4'd5;

   typedef struct packed {
      logic [OUT_W-1:0] pixels;
      logic             last;
   } line_group_type;

   // Tracks register state and the line being filled; queues the groups each
   // completed line replays.
   class scanline_scoreboard_type;
      logic [2:0]       mode;
      logic             css_bit;
      logic [3:0]       fg_set0;
      logic [3:0]       fg_set1;
      logic [OUT_W-1:0] line_buf [GROUPS_PER_LINE];
      int unsigned      fill_pos;
      line_group_type   pending_groups [$];
      int               errors;

      function new();
         mode      = MODE_1C;
         css_bit   = 1'b0;
         fg_set0   = FG_SET0_RESET;
         fg_set1   = FG_SET1_RESET;
         fill_pos  = 0;
         errors    = 0;
         clear_line();
      endfunction

      function void clear_line();
         for (int g = 0; g < GROUPS_PER_LINE; g++) line_buf[g] = '0;
      endfunction

      function void note_failure(string msg);
         errors++;
         if (errors <= MAX_REPORTS) $display("%s", msg);
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_GRAPHICS_MODE: mode = val[2:0];
            CSR_COLOR_SET:     css_bit = val[0];
            CSR_FG_SET0:       fg_set0 = val[3:0];
            CSR_FG_SET1:       fg_set1 = val[3:0];
            default: ;
         endcase
      endfunction

      // pixels past the end of the line are dropped
      function void put_run(logic [3:0] pix, int unsigned count);
         int unsigned slot;
         for (int k = 0; k < count; k++) begin
            if (fill_pos < LINE_PIXELS) begin
               slot = fill_pos % GROUP_PIXELS;
               line_buf[fill_pos / GROUP_PIXELS][4*(GROUP_PIXELS-1-slot) +: 4] = pix;
               fill_pos++;
            end
         end
      endfunction

      function void note_byte(logic [7:0] b);
         logic [3:0]     fg;
         logic [3:0]     mono;
         int unsigned    rows;
         line_group_type grp;
         fg = css_bit ? fg_set1 : fg_set0;
         if (!mode[0]) begin
            for (int k = 3; k >= 0; k--)
               put_run({1'b0, css_bit, b[2*k +: 2]} + 4'd1, (mode == MODE_1C) ? 4 : 2);
         end else if (mode == MODE_6R) begin
            mono = (fg == PIX_GREEN) ? PIX_GREEN : PIX_BUFF;
            for (int k = 7; k >= 0; k--) put_run(b[k] ? mono : PIX_BLACK, 1);
         end else begin
            for (int k = 7; k >= 0; k--) put_run(b[k] ? fg : PIX_BLACK, 2);
         end
         if (fill_pos >= LINE_PIXELS) begin
            case (mode)
               MODE_1C, MODE_1R, MODE_2C: rows = 3;
               MODE_2R, MODE_3C:          rows = 2;
               default:                   rows = 1;
            endcase
            for (int r = 0; r < rows; r++) begin
               for (int g = 0; g < GROUPS_PER_LINE; g++) begin
                  grp.pixels = line_buf[g];
                  grp.last   = (r == rows - 1) && (g == GROUPS_PER_LINE - 1);
                  pending_groups.push_back(grp);
               end
            end
            clear_line();
            fill_pos = 0;
         end
      endfunction

      function void check_group(logic [OUT_W-1:0] pixels, logic last);
         line_group_type want;
         if (pending_groups.size() == 0) begin
            note_failure($sformatf("unexpected group %h last %b", pixels, last));
            return;
         end
         want = pending_groups.pop_front();
         if (want.pixels !== pixels || want.last !== last)
            note_failure($sformatf("group mismatch: expected %h last %b, got %h last %b",
                                   want.pixels, want.last, pixels, last));
      endfunction
   endclass

   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   req_valid      = 1'b0;
   logic                   req_stall;
   logic [7:0]             req_video_byte = '0;
   logic                   rsp_valid;
   logic                   rsp_stall      = 1'b0;
   logic [OUT_W-1:0]       rsp_pixel_group;
   logic                   rsp_last_of_run;
   logic                   csr_valid      = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index      = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata      = '0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_requests = 0;
   int holds_done    = 0;
   int bytes_taken   = 0;

   scanline_scoreboard_type expander = new();

   graphics_mode_scanline_expander_core #(
      .LINE_PIXELS (LINE_PIXELS),
      .GROUP_PIXELS(GROUP_PIXELS)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_video_byte (req_video_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_group(rsp_pixel_group),
      .rsp_last_of_run(rsp_last_of_run),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #2 clock = ~clock;

   initial begin
      #20_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // result side: check transfers, then pick next stall (long hold on request)
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            expander.check_group(rsp_pixel_group, rsp_last_of_run);
         if (holds_done != hold_requests) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // leaves valid high after the transfer; caller drops it after the last byte
   task automatic push_byte(logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_video_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expander.note_byte(b);
      bytes_taken++;
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      expander.write_reg(idx, val);
   endtask

   // no output pending, and the last byte has had time to settle into the line
   task automatic wait_idle();
      while (expander.pending_groups.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // upper data bits are don't-care, so they carry random junk
   task automatic program_regs(logic [2:0] m, logic cs, logic [3:0] f0, logic [3:0] f1);
      logic [CSR_DATA_W-1:0] junk;
      junk = CSR_DATA_W'($urandom);
      write_reg(CSR_GRAPHICS_MODE, {junk[CSR_DATA_W-1:3], m});
      junk = CSR_DATA_W'($urandom);
      write_reg(CSR_COLOR_SET, {junk[CSR_DATA_W-1:1], cs});
      junk = CSR_DATA_W'($urandom);
      write_reg(CSR_FG_SET0, {junk[CSR_DATA_W-1:4], f0});
      junk = CSR_DATA_W'($urandom);
      write_reg(CSR_FG_SET1, {junk[CSR_DATA_W-1:4], f1});
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] random_byte();
      case ($urandom_range(9))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [3:0] pick_fg();
      case ($urandom_range(3))
         0:       return 4'd0;
         1:       return PIX_GREEN;
         2:       return 4'd15;
         default: return 4'($urandom_range(15));
      endcase
   endfunction

   task automatic run_phase(logic [2:0] m, logic cs, logic [3:0] f0, logic [3:0] f1,
                            int n, bit pressure);
      wait_idle();
      program_regs(m, cs, f0, f1);
      if (pressure) hold_requests++;
      repeat (n) push_byte(random_byte());
      req_valid <= 1'b0;
   endtask

   initial begin
      logic [7:0] directed [16];
      logic [2:0] m;
      int         phase_no;
      int         per_line;
      int         n;
      int         target;
      directed = '{8'h00, 8'hFF, 8'h1B, 8'hE4, 8'h01, 8'h02, 8'h04, 8'h08,
                   8'h10, 8'h20, 8'h40, 8'h80, 8'h55, 8'hAA, 8'h0F, 8'hF0};
      phase_no = 0;
      send_idle_pct = 18;
      recv_idle_pct = 60;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // unused indexes must be ignored; then reset values, mode 1C
      write_reg(8'hFF, 8'($urandom));
      write_reg(CSR_INDEX_W'($urandom_range(4, 254)), 8'($urandom));
      program_regs(MODE_1C, 1'b0, FG_SET0_RESET, FG_SET1_RESET);
      foreach (directed[i]) push_byte(directed[i]);
      req_valid <= 1'b0;

      // line overrun: 6R up to 8 pixels short, then one 16-pixel byte in 1R
      wait_idle();
      program_regs(MODE_6R, 1'b0, PIX_GREEN, 4'd15);
      while (expander.fill_pos != LINE_PIXELS - 8) push_byte(random_byte());
      req_valid <= 1'b0;
      run_phase(MODE_1R, 1'b1, 4'd15, 4'd0, 1, 1'b0);

      for (int stage = 0; stage < 3; stage++) begin
         if (stage == 1) begin
            send_idle_pct = 60;
            recv_idle_pct = 18;
         end else if (stage == 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            // long output hold while the sender keeps offering 1C lines
            run_phase(MODE_1C, 1'($urandom_range(1)), pick_fg(), pick_fg(), 64, 1'b1);
         end
         target = bytes_taken + 120;
         while (bytes_taken < target) begin
            m = (phase_no < 8) ? 3'(phase_no) : 3'($urandom_range(7));
            per_line = (m == MODE_6R) ? 32 : 16;
            n = $urandom_range(1, 2) * per_line;
            // partial lines carry over into the next mode
            if ($urandom_range(3) == 0) n += $urandom_range(1, per_line - 1);
            run_phase(m, 1'($urandom_range(1)), pick_fg(), pick_fg(), n, 1'b0);
            phase_no++;
         end
      end

      while (expander.pending_groups.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      if (expander.errors == 0 && expander.pending_groups.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
